/* design/hdtb_pkg.sv */
// ----------------------------------------------------------------------------
// hdtb_pkg
// shared constants and controller/datapath interface types of the
// canonical huffman decode table builder
// ----------------------------------------------------------------------------
`default_nettype none

package hdtb_pkg;

  localparam int unsigned NUM_LENGTHS         = 15;
  localparam int unsigned LEN_W               = 4;
  localparam int unsigned SYM_W               = 8;
  localparam int unsigned CODE_W              = 15;
  localparam int unsigned OCNT_W              = 9;
  localparam int unsigned DEF_MAX_SYMBOLS     = 256;
  localparam int unsigned DEF_MAX_CODE_LENGTH = 15;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_READ   = 1'b1;
  localparam logic REC_LENGTH  = 1'b0;
  localparam logic REC_SLOT    = 1'b1;

  typedef struct packed {
    logic load;
    logic build_clr;
    logic i_clr;
    logic i_inc;
    logic hist_upd;
    logic k_clr;
    logic pfx_step;
    logic rank_init;
    logic j_clr;
    logic j_inc;
    logic rank_cmp;
    logic rank_wr;
    logic emit;
    logic rd_issue;
    logic rd_out;
    logic cnt_clr;
  } hdtb_cmd_t;

  typedef struct packed {
    logic i_end;
    logic j_end;
    logic k_last;
    logic a_used;
    logic out_free;
  } hdtb_stat_t;

endpackage

`default_nettype wire

/* design/huffman_decode_table_builder_unit.sv */
// ----------------------------------------------------------------------------
// huffman_decode_table_builder_unit
// canonical huffman decode table builder with sorted symbol readback
// ----------------------------------------------------------------------------
// A load item is written to the triplet store when accepted and the store is
// not full. The item marked last starts a build that walks the triplet store:
// one histogram pass over the triplets, prefix sums over the 15 lengths, then a
// ranking pass that compares each used triplet with all n stored triplets and
// skips each unused one (one shared compare unit), before the 15 per-length
// records leave one per cycle while the receiver is ready. A read item returns
// its slot through the read register and then the output register. No item is
// accepted while a build or a read is in progress.
`default_nettype none

module huffman_decode_table_builder_unit import hdtb_pkg::*; #(
  parameter int unsigned MAX_SYMBOLS     = DEF_MAX_SYMBOLS,
  parameter int unsigned MAX_CODE_LENGTH = DEF_MAX_CODE_LENGTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // symbol[7:0], code_bits[22:8], code_size[26:23], read_slot[34:27], zero
  input  wire logic [39:0] s_axis_tdata_i,
  // kind
  input  wire logic        s_axis_tuser_i,
  // final_triplet
  input  wire logic        s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // length_id[3:0], length_count[12:4], smallest_code[27:13],
  // start_slot[36:28], slot_symbol[44:37], zero
  output logic [47:0]      m_axis_tdata_o,
  // record_kind
  output logic             m_axis_tuser_o,
  // run_end
  output logic             m_axis_tlast_o
);

  hdtb_cmd_t         cmd;
  hdtb_stat_t        stat;
  logic [LEN_W-1:0]  length_id;
  logic [OCNT_W-1:0] length_count;
  logic [CODE_W-1:0] smallest_code;
  logic [OCNT_W-1:0] start_slot;
  logic [SYM_W-1:0]  slot_symbol;

  hdtb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .kind_i     (s_axis_tuser_i),
    .final_i    (s_axis_tlast_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  hdtb_datapath #(
    .MAX_SYMBOLS     (MAX_SYMBOLS),
    .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .symbol_i        (s_axis_tdata_i[7:0]),
    .code_bits_i     (s_axis_tdata_i[22:8]),
    .code_size_i     (s_axis_tdata_i[26:23]),
    .read_slot_i     (s_axis_tdata_i[34:27]),
    .out_ready_i     (m_axis_tready_i),
    .out_valid_o     (m_axis_tvalid_o),
    .record_kind_o   (m_axis_tuser_o),
    .length_id_o     (length_id),
    .length_count_o  (length_count),
    .smallest_code_o (smallest_code),
    .start_slot_o    (start_slot),
    .slot_symbol_o   (slot_symbol),
    .run_end_o       (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {3'b000, slot_symbol, start_slot, smallest_code,
                           length_count, length_id};

endmodule

`default_nettype wire

/* design/hdtb_datapath.sv */
// ----------------------------------------------------------------------------
// hdtb_datapath
// triplet store, length tables, sorted symbol store and result register
// ----------------------------------------------------------------------------
`default_nettype none

module hdtb_datapath import hdtb_pkg::*; #(
  parameter int unsigned MAX_SYMBOLS     = DEF_MAX_SYMBOLS,
  parameter int unsigned MAX_CODE_LENGTH = DEF_MAX_CODE_LENGTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire hdtb_cmd_t         cmd_i,
  output hdtb_stat_t             stat_o,
  input  wire logic [SYM_W-1:0]  symbol_i,
  input  wire logic [CODE_W-1:0] code_bits_i,
  input  wire logic [LEN_W-1:0]  code_size_i,
  input  wire logic [7:0]        read_slot_i,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic                   record_kind_o,
  output logic [LEN_W-1:0]       length_id_o,
  output logic [OCNT_W-1:0]      length_count_o,
  output logic [CODE_W-1:0]      smallest_code_o,
  output logic [OCNT_W-1:0]      start_slot_o,
  output logic [SYM_W-1:0]       slot_symbol_o,
  output logic                   run_end_o
);

  localparam int unsigned AW = $clog2(MAX_SYMBOLS);
  localparam int unsigned CW = $clog2(MAX_SYMBOLS + 1);

  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } trip_t;

  trip_t             store_q [MAX_SYMBOLS];
  trip_t             a_q, b_q;
  logic [SYM_W-1:0]  sorted_q [MAX_SYMBOLS];
  logic [MAX_SYMBOLS-1:0] vld_q;
  logic [CW-1:0]     cnt_q, i_q, j_q, rank_q, nxt_q;
  logic [CW-1:0]     hist_q  [NUM_LENGTHS];
  logic [CODE_W-1:0] fcode_q [NUM_LENGTHS];
  logic [CW-1:0]     start_q [NUM_LENGTHS];
  logic [LEN_W-1:0]  k_q;
  logic [SYM_W-1:0]  rds_q;
  logic              rdv_q;
  logic [LEN_W-1:0]  a_idx;
  logic [31:0]       slot_ext;
  logic [31:0]       hist_ext, start_ext;
  logic              b_match;

  assign a_idx    = a_q.len - LEN_W'(1);
  assign slot_ext = 32'(read_slot_i);
  assign hist_ext  = 32'(hist_q[k_q]);
  assign start_ext = 32'(start_q[k_q]);
  assign b_match  = (b_q.len == a_q.len) &&
                    ((b_q.code < a_q.code) || ((b_q.code == a_q.code) && (j_q < i_q)));

  assign stat_o.i_end    = (i_q == cnt_q);
  assign stat_o.j_end    = (j_q == cnt_q);
  assign stat_o.k_last   = (k_q == LEN_W'(NUM_LENGTHS - 1));
  assign stat_o.a_used   = (a_q.len != '0) && (32'(a_q.len) <= MAX_CODE_LENGTH);
  assign stat_o.out_free = !out_valid_o || out_ready_i;

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (cnt_q != CW'(MAX_SYMBOLS))) begin
      store_q[cnt_q[AW-1:0]] <= '{sym: symbol_i, code: code_bits_i, len: code_size_i};
    end
    a_q <= store_q[i_q[AW-1:0]];
    b_q <= store_q[j_q[AW-1:0]];
    if (cmd_i.rank_wr) begin
      sorted_q[rank_q[AW-1:0]] <= a_q.sym;
    end
    if (cmd_i.rd_issue) begin
      rds_q <= sorted_q[slot_ext[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      i_q    <= '0;
      j_q    <= '0;
      rank_q <= '0;
      nxt_q  <= '0;
      k_q    <= '0;
      vld_q  <= '0;
      rdv_q  <= 1'b0;
      for (int n = 0; n < NUM_LENGTHS; n++) begin
        hist_q[n]  <= '0;
        fcode_q[n] <= '0;
        start_q[n] <= '0;
      end
      out_valid_o     <= 1'b0;
      record_kind_o   <= REC_LENGTH;
      length_id_o     <= '0;
      length_count_o  <= '0;
      smallest_code_o <= '0;
      start_slot_o    <= '0;
      slot_symbol_o   <= '0;
      run_end_o       <= 1'b0;
    end else begin
      if (cmd_i.load && (cnt_q != CW'(MAX_SYMBOLS))) cnt_q <= cnt_q + CW'(1);
      if (cmd_i.cnt_clr) cnt_q <= '0;
      if (cmd_i.build_clr) begin
        vld_q <= '0;
        nxt_q <= '0;
        i_q   <= '0;
        for (int n = 0; n < NUM_LENGTHS; n++) begin
          hist_q[n]  <= '0;
          fcode_q[n] <= '0;
          start_q[n] <= '0;
        end
      end
      if (cmd_i.build_clr || cmd_i.k_clr) begin
        k_q <= '0;
      end else if (cmd_i.pfx_step || cmd_i.emit) begin
        k_q <= k_q + LEN_W'(1);
      end
      if (cmd_i.i_clr) i_q <= '0;
      if (cmd_i.i_inc) i_q <= i_q + CW'(1);
      if (cmd_i.j_clr) j_q <= '0;
      if (cmd_i.j_inc) j_q <= j_q + CW'(1);
      if (cmd_i.hist_upd && stat_o.a_used) begin
        if ((hist_q[a_idx] == '0) || (a_q.code < fcode_q[a_idx])) begin
          fcode_q[a_idx] <= a_q.code;
        end
        hist_q[a_idx] <= hist_q[a_idx] + CW'(1);
      end
      if (cmd_i.pfx_step) begin
        if (hist_q[k_q] != '0) start_q[k_q] <= nxt_q;
        nxt_q <= nxt_q + hist_q[k_q];
      end
      if (cmd_i.rank_init) rank_q <= start_q[a_idx];
      if (cmd_i.rank_cmp && b_match) rank_q <= rank_q + CW'(1);
      if (cmd_i.rank_wr) vld_q[rank_q[AW-1:0]] <= 1'b1;
      if (cmd_i.rd_issue) begin
        rdv_q <= (slot_ext < MAX_SYMBOLS) && vld_q[slot_ext[AW-1:0]];
      end
      if (cmd_i.emit || cmd_i.rd_out) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      if (cmd_i.emit) begin
        record_kind_o   <= REC_LENGTH;
        length_id_o     <= k_q + LEN_W'(1);
        length_count_o  <= hist_ext[OCNT_W-1:0];
        smallest_code_o <= fcode_q[k_q];
        start_slot_o    <= start_ext[OCNT_W-1:0];
        slot_symbol_o   <= '0;
        run_end_o       <= stat_o.k_last;
      end
      if (cmd_i.rd_out) begin
        record_kind_o   <= REC_SLOT;
        length_id_o     <= '0;
        length_count_o  <= '0;
        smallest_code_o <= '0;
        start_slot_o    <= '0;
        slot_symbol_o   <= rdv_q ? rds_q : '0;
        run_end_o       <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* design/hdtb_ctrl.sv */
// ----------------------------------------------------------------------------
// hdtb_ctrl
// sequencer for loading, histogram, prefix, ranking, record emission and slot reads
// ----------------------------------------------------------------------------
`default_nettype none

module hdtb_ctrl import hdtb_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       kind_i,
  input  wire logic       final_i,
  input  wire hdtb_stat_t stat_i,
  output hdtb_cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_HIST_RD, ST_HIST_UPD, ST_PFX, ST_RI, ST_RI2,
    ST_RJ, ST_RC, ST_RW, ST_EMIT, ST_RD_OUT
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (kind_i == KIND_READ) begin
            cmd_o.rd_issue = 1'b1;
            state_d        = ST_RD_OUT;
          end else begin
            cmd_o.load = 1'b1;
            if (final_i) begin
              cmd_o.build_clr = 1'b1;
              state_d         = ST_HIST_RD;
            end
          end
        end
      end
      ST_HIST_RD: state_d = stat_i.i_end ? ST_PFX : ST_HIST_UPD;
      ST_HIST_UPD: begin
        cmd_o.hist_upd = 1'b1;
        cmd_o.i_inc    = 1'b1;
        state_d        = ST_HIST_RD;
      end
      ST_PFX: begin
        cmd_o.pfx_step = 1'b1;
        if (stat_i.k_last) begin
          cmd_o.k_clr = 1'b1;
          cmd_o.i_clr = 1'b1;
          state_d     = ST_RI;
        end
      end
      ST_RI: state_d = stat_i.i_end ? ST_EMIT : ST_RI2;
      ST_RI2: begin
        if (stat_i.a_used) begin
          cmd_o.rank_init = 1'b1;
          cmd_o.j_clr     = 1'b1;
          state_d         = ST_RJ;
        end else begin
          cmd_o.i_inc = 1'b1;
          state_d     = ST_RI;
        end
      end
      ST_RJ: state_d = stat_i.j_end ? ST_RW : ST_RC;
      ST_RC: begin
        cmd_o.rank_cmp = 1'b1;
        cmd_o.j_inc    = 1'b1;
        state_d        = ST_RJ;
      end
      ST_RW: begin
        cmd_o.rank_wr = 1'b1;
        cmd_o.i_inc   = 1'b1;
        state_d       = ST_RI;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.k_last) begin
            cmd_o.cnt_clr = 1'b1;
            state_d       = ST_IDLE;
          end
        end
      end
      ST_RD_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.rd_out = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* bench/table_build_checker.sv */
// ----------------------------------------------------------------------------
// table_build_checker
// watches both stream channels of the decode table builder, keeps its own
// copy of the triplet store and decode tables, predicts every record and
// slot read, and compares each output item with the oldest prediction
// ----------------------------------------------------------------------------
`default_nettype none

module table_build_checker import hdtb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  input  wire logic        s_axis_tready_i,
  input  wire logic [39:0] s_axis_tdata_i,
  input  wire logic        s_axis_tuser_i,
  input  wire logic        s_axis_tlast_i,
  input  wire logic        m_axis_tvalid_i,
  input  wire logic        m_axis_tready_i,
  input  wire logic [47:0] m_axis_tdata_i,
  input  wire logic        m_axis_tuser_i,
  input  wire logic        m_axis_tlast_i,
  output int               errors_o,
  output int               pending_o
);

  localparam int unsigned MAXSYM = DEF_MAX_SYMBOLS;

  typedef struct packed {
    logic              rec_kind;
    logic [LEN_W-1:0]  len_id;
    logic [8:0]        count;
    logic [CODE_W-1:0] low_code;
    logic [8:0]        first_slot;
    logic [SYM_W-1:0]  symbol;
    logic              run_end;
  } table_rec_t;

  logic [SYM_W-1:0]  trip_sym  [MAXSYM];
  logic [CODE_W-1:0] trip_code [MAXSYM];
  logic [LEN_W-1:0]  trip_len  [MAXSYM];
  int unsigned       loaded;
  int unsigned       len_hist  [NUM_LENGTHS];
  logic [CODE_W-1:0] low_codes [NUM_LENGTHS];
  int unsigned       slot_base [NUM_LENGTHS];
  logic [SYM_W-1:0]  sorted_sym[MAXSYM];

  table_rec_t expected_records[$];

  task automatic clear_tables();
    for (int k = 0; k < NUM_LENGTHS; k++) begin
      len_hist[k] = 0;
      low_codes[k] = '0;
      slot_base[k] = 0;
    end
    for (int k = 0; k < MAXSYM; k++) sorted_sym[k] = '0;
  endtask

  task automatic build_decode_tables();
    int unsigned picked [MAXSYM];
    int unsigned n;
    int unsigned j;
    int unsigned next_slot;
    table_rec_t rec;
    next_slot = 0;
    clear_tables();
    for (int unsigned i = 0; i < loaded; i++)
      if (trip_len[i] != 0 && trip_len[i] <= DEF_MAX_CODE_LENGTH)
        len_hist[trip_len[i]-1]++;
    for (int unsigned len = 1; len <= NUM_LENGTHS; len++) begin
      if (len_hist[len-1] != 0) begin
        n = 0;
        for (int unsigned i = 0; i < loaded; i++) begin
          if (trip_len[i] == len) begin
            j = n;
            while (j > 0 && trip_code[picked[j-1]] > trip_code[i]) begin
              picked[j] = picked[j-1];
              j--;
            end
            picked[j] = i;
            n++;
          end
        end
        low_codes[len-1] = trip_code[picked[0]];
        slot_base[len-1] = next_slot;
        for (j = 0; j < n && next_slot < MAXSYM; j++) begin
          sorted_sym[next_slot] = trip_sym[picked[j]];
          next_slot++;
        end
      end
    end
    for (int unsigned len = 1; len <= NUM_LENGTHS; len++) begin
      rec = '0;
      rec.rec_kind   = REC_LENGTH;
      rec.len_id     = len[LEN_W-1:0];
      rec.count      = len_hist[len-1][8:0];
      rec.low_code   = low_codes[len-1];
      rec.first_slot = slot_base[len-1][8:0];
      rec.run_end    = (len == NUM_LENGTHS);
      expected_records.push_back(rec);
    end
    loaded = 0;
  endtask

  task automatic apply_item(input logic kind, input logic [39:0] data, input logic last);
    table_rec_t rec;
    if (kind == KIND_READ) begin
      rec = '0;
      rec.rec_kind = REC_SLOT;
      rec.symbol   = sorted_sym[data[34:27]];
      rec.run_end  = 1'b1;
      expected_records.push_back(rec);
    end else begin
      if (loaded < MAXSYM) begin
        trip_sym[loaded]  = data[7:0];
        trip_code[loaded] = data[22:8];
        trip_len[loaded]  = data[26:23];
        loaded++;
      end
      if (last) build_decode_tables();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch: %s got 0x%0h expected 0x%0h at %0t", what, got, want, $time);
    errors_o++;
  endtask

  task automatic check_output();
    table_rec_t want;
    if (expected_records.size() == 0) begin
      report_mismatch("unexpected output item", m_axis_tdata_i[31:0], 32'd0);
      return;
    end
    want = expected_records.pop_front();
    if (m_axis_tuser_i !== want.rec_kind)
      report_mismatch("record_kind", m_axis_tuser_i, want.rec_kind);
    if (m_axis_tdata_i[3:0] !== want.len_id)
      report_mismatch("length_id", m_axis_tdata_i[3:0], want.len_id);
    if (m_axis_tdata_i[12:4] !== want.count)
      report_mismatch("length_count", m_axis_tdata_i[12:4], want.count);
    if (m_axis_tdata_i[27:13] !== want.low_code)
      report_mismatch("smallest_code", m_axis_tdata_i[27:13], want.low_code);
    if (m_axis_tdata_i[36:28] !== want.first_slot)
      report_mismatch("start_slot", m_axis_tdata_i[36:28], want.first_slot);
    if (m_axis_tdata_i[44:37] !== want.symbol)
      report_mismatch("slot_symbol", m_axis_tdata_i[44:37], want.symbol);
    if (m_axis_tlast_i !== want.run_end)
      report_mismatch("run_end", m_axis_tlast_i, want.run_end);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded = 0;
      errors_o = 0;
      clear_tables();
      expected_records.delete();
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) check_output();
      if (s_axis_tvalid_i && s_axis_tready_i)
        apply_item(s_axis_tuser_i, s_axis_tdata_i, s_axis_tlast_i);
    end
    pending_o = expected_records.size();
  end

endmodule

`default_nettype wire

/* bench/huffman_decode_table_builder_unit_tb.sv */
// ----------------------------------------------------------------------------
// huffman_decode_table_builder_unit_tb
// drives triplet sets, builds and slot reads into the table builder under
// changing idle patterns and back pressure; a checker module predicts and
// compares every output item
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_decode_table_builder_unit_tb;
  import hdtb_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = KIND_LOAD;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        m_axis_tlast_o;

  int errors;
  int pending;
  int phase = 0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;
  bit hold_done = 1'b0;
  int n_loads = 0;
  int n_reads = 0;
  int n_builds = 0;
  int n_items = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  huffman_decode_table_builder_unit dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i, .s_axis_tlast_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o, .m_axis_tlast_o
  );

  table_build_checker chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i,
    .s_axis_tuser_i, .s_axis_tlast_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .m_axis_tuser_i(m_axis_tuser_o), .m_axis_tlast_i(m_axis_tlast_o),
    .errors_o(errors), .pending_o(pending)
  );

  // receiver: random stalls in the first two phases, one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_cnt = 400;
      hold_done = 1'b1;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready_i <= 1'b0;
    end else if (phase == 0) begin
      m_axis_tready_i <= ($urandom_range(99) >= 69);
    end else if (phase == 1) begin
      m_axis_tready_i <= ($urandom_range(99) >= 30);
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  task automatic send_item(input logic kind, input logic [7:0] sym,
                           input logic [14:0] code, input logic [3:0] size,
                           input logic last, input logic [7:0] slot);
    int gap_pct;
    gap_pct = (phase == 0) ? 30 : (phase == 1) ? 69 : 0;
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tlast_i  <= last;
    s_axis_tdata_i  <= {5'b0, slot, size, code, sym};
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
    n_items++;
    if (kind == KIND_READ) n_reads++;
    else n_loads++;
    if (kind == KIND_LOAD && last) n_builds++;
  endtask

  task automatic load(input logic [7:0] sym, input logic [14:0] code,
                      input logic [3:0] size, input logic last);
    send_item(KIND_LOAD, sym, code, size, last, 8'($urandom));
  endtask

  task automatic read_slot(input logic [7:0] slot);
    send_item(KIND_READ, 8'($urandom), 15'($urandom), 4'($urandom),
              1'($urandom_range(1)), slot);
  endtask

  task automatic random_set(input int size_n);
    logic [14:0] code;
    for (int k = 0; k < size_n; k++) begin
      code = ($urandom_range(3) == 0) ? 15'($urandom_range(3)) : 15'($urandom);
      if ($urandom_range(9) == 0) read_slot(8'($urandom));
      load(8'($urandom), code, 4'($urandom), k == size_n - 1);
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reads after reset, extremes of the slot
    read_slot(8'd0);
    read_slot(8'd255);
    // extremes, unused length, equal codes within one length
    load(8'd255, 15'h7fff, 4'd15, 1'b0);
    load(8'd0, 15'd0, 4'd1, 1'b0);
    load(8'd7, 15'd9, 4'd0, 1'b0);
    load(8'd5, 15'd3, 4'd3, 1'b0);
    load(8'd6, 15'd3, 4'd3, 1'b0);
    load(8'd4, 15'd1, 4'd3, 1'b0);
    load(8'd170, 15'd0, 4'd15, 1'b1);
    for (int k = 0; k < 6; k++) read_slot(8'(k));
    read_slot(8'd255);
    // build with nothing used, slots read back as zero
    load(8'd85, 15'h5555, 4'd0, 1'b1);
    read_slot(8'd0);
    load(8'd1, 15'h2aaa, 4'd8, 1'b1);
    read_slot(8'd0);
    read_slot(8'd1);

    while (n_items < 216) begin
      phase = (n_items < 90) ? 0 : (n_items < 160) ? 1 : 2;
      if (phase == 2 && !hold_req) hold_req = 1'b1;
      if ($urandom_range(3) == 0) read_slot(8'($urandom_range(3) == 0 ? $urandom : $urandom_range(9)));
      else random_set($urandom_range(1, 10));
    end

    // sender pauses until the output side has drained
    s_axis_tvalid_i <= 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
    read_slot(8'd0);
    read_slot(8'd255);
    s_axis_tvalid_i <= 1'b0;

    wait (pending == 0);
    repeat (50) @(negedge clk_i);
    $display("covered %0d loads, %0d slot reads and %0d table builds", n_loads, n_reads,
             n_builds);
    $display("including equal codes, unused lengths, empty builds and a long output hold-off");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d items still expected", pending);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
